// ===== hw/rtl/mpph_pkg.sv =====
// ----------------------------------------------------------------------------
// mpph_pkg
// Shared constants and the result record of the multipart part header parser.
// ----------------------------------------------------------------------------
package mpph_pkg;

  localparam int unsigned DEF_MAX_BLOB_BYTES = 65536;

  localparam logic [7:0] LF     = 8'h0a;
  localparam logic [7:0] DQUOTE = 8'h22;
  localparam logic [7:0] SQUOTE = 8'h27;

  localparam int unsigned HDR_FIRST    = 21;
  localparam int unsigned HDR_LAST     = 29;
  localparam int unsigned LINE1_MIN    = 30;
  localparam int unsigned TYPE_SKIP    = 14;
  localparam int unsigned NAME_OFS     = 6;
  localparam int unsigned FILENAME_OFS = 10;
  localparam int unsigned NAME_BACK    = 4;
  localparam int unsigned FILENAME_BACK = 8;

  localparam logic [7:0] FORM_WORD [9] = '{
    8'h66, 8'h6f, 8'h72, 8'h6d, 8'h2d, 8'h64, 8'h61, 8'h74, 8'h61
  };
  localparam logic [39:0] NAME_WORD     = "name=";
  localparam logic [71:0] FILENAME_WORD = "filename=";

  typedef struct packed {
    logic        ok;
    logic        invalid_quote;
    logic        name_found;
    logic [15:0] name_start;
    logic [16:0] name_length;
    logic        filename_found;
    logic [15:0] filename_start;
    logic [16:0] filename_length;
    logic [15:0] type_start;
    logic [16:0] type_length;
    logic [16:0] content_start;
    logic [16:0] blob_length;
  } result_t;

endpackage

// ===== hw/rtl/mpph_byte_if.sv =====
// ----------------------------------------------------------------------------
// mpph_byte_if
// Byte stream channel: one part byte per transaction, last byte marked.
// ----------------------------------------------------------------------------
interface mpph_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       is_last;

  modport source (output valid, output byte_value, output is_last, input ready);
  modport sink (input valid, input byte_value, input is_last, output ready);
endinterface

// ===== hw/rtl/mpph_result_if.sv =====
// ----------------------------------------------------------------------------
// mpph_result_if
// Result channel: field locations of one parsed part per transaction.
// ----------------------------------------------------------------------------
interface mpph_result_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic        invalid_quote;
  logic        name_found;
  logic [15:0] name_start;
  logic [16:0] name_length;
  logic        filename_found;
  logic [15:0] filename_start;
  logic [16:0] filename_length;
  logic [15:0] type_start;
  logic [16:0] type_length;
  logic [16:0] content_start;
  logic [16:0] blob_length;

  modport source (
    output valid, input ready,
    output ok, output invalid_quote,
    output name_found, output name_start, output name_length,
    output filename_found, output filename_start, output filename_length,
    output type_start, output type_length, output content_start, output blob_length
  );
  modport sink (
    input valid, output ready,
    input ok, input invalid_quote,
    input name_found, input name_start, input name_length,
    input filename_found, input filename_start, input filename_length,
    input type_start, input type_length, input content_start, input blob_length
  );
endinterface

// ===== hw/rtl/multipart_part_header_parser_unit.sv =====
// ----------------------------------------------------------------------------
// multipart_part_header_parser_unit
// Locates the name, filename, content type and content of one multipart part.
//
// Takes one byte per cycle but for the stall below, and reports one result
// transaction per part after its last byte passes the input register, then
// the result register. Bytes that are not last flow through at full rate
// regardless of the result side; a last byte waits in the input register
// only while the previous result is still held, which is the one place the
// stream can stall. Values are reported as offsets and lengths into the part;
// bytes beyond MAX_BLOB_BYTES are counted as an overflow and fail the part.
// ----------------------------------------------------------------------------
module multipart_part_header_parser_unit #(
  parameter int unsigned MAX_BLOB_BYTES = mpph_pkg::DEF_MAX_BLOB_BYTES
) (
  input logic           clk,
  input logic           rst,
  mpph_byte_if.sink     req,
  mpph_result_if.source rsp
);
  import mpph_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_go;
  logic       out_valid;
  result_t    scan_res;
  result_t    result;

  assign s1_go     = s1_valid && (!s1_last || !out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
    if (req.ready) begin
      s1_byte <= req.byte_value;
      s1_last <= req.is_last;
    end
  end

  mpph_scan #(
    .MAX_BLOB_BYTES(MAX_BLOB_BYTES)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .step       (s1_go),
    .byte_value (s1_byte),
    .is_last    (s1_last),
    .res        (scan_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_last) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_go && s1_last) begin
      result <= scan_res;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.ok              = result.ok;
  assign rsp.invalid_quote   = result.invalid_quote;
  assign rsp.name_found      = result.name_found;
  assign rsp.name_start      = result.name_start;
  assign rsp.name_length     = result.name_length;
  assign rsp.filename_found  = result.filename_found;
  assign rsp.filename_start  = result.filename_start;
  assign rsp.filename_length = result.filename_length;
  assign rsp.type_start      = result.type_start;
  assign rsp.type_length     = result.type_length;
  assign rsp.content_start   = result.content_start;
  assign rsp.blob_length     = result.blob_length;

  a_last_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_last && out_valid && !rsp.ready |=> s1_valid && s1_last)
    else $error("last byte lost while result pending");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.ok |-> !result.name_found && !result.filename_found &&
      result.type_length == '0 && result.content_start == '0)
    else $error("failed part carries field locations");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result.name_found || result.filename_found) |-> result.ok)
    else $error("value found on failed part");

  a_ok_length: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.ok |-> result.content_start <= result.blob_length)
    else $error("content starts beyond end of part");

endmodule

// ===== hw/rtl/mpph_scan.sv =====
// ----------------------------------------------------------------------------
// mpph_scan
// Per-byte scanner: line tracking, header word check, name= and filename=
// matchers, value end search, and the result record built from the state
// left by the last byte of a part.
// ----------------------------------------------------------------------------
module mpph_scan #(
  parameter int unsigned MAX_BLOB_BYTES = mpph_pkg::DEF_MAX_BLOB_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        byte_value,
  input  logic              is_last,
  output mpph_pkg::result_t res
);
  import mpph_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_BLOB_BYTES + 1);
  localparam int unsigned PW1   = POS_W + 1;
  localparam int unsigned EW    = (POS_W > 17) ? POS_W : 17;
  localparam logic [EW-1:0] BLOB_OVER = EW'(MAX_BLOB_BYTES + 1);

  localparam logic [1:0] LINE_ONE   = 2'd0;
  localparam logic [1:0] LINE_TWO   = 2'd1;
  localparam logic [1:0] LINE_THREE = 2'd2;
  localparam logic [1:0] LINE_REST  = 2'd3;

  localparam logic [1:0] PROG_NONE   = 2'd0;
  localparam logic [1:0] PROG_OPEN   = 2'd1;
  localparam logic [1:0] PROG_CLOSED = 2'd2;

  logic [POS_W-1:0] pos, pos_next;
  logic [1:0]       line_idx, line_idx_next;
  logic [POS_W-1:0] l1_end, l1_end_next;
  logic [POS_W-1:0] l2_end, l2_end_next;
  logic [POS_W-1:0] l3_end, l3_end_next;
  logic             l3_seen, l3_seen_next;
  logic             hdr_bad, hdr_bad_next;
  logic [7:0]       recent [8];
  logic [7:0]       recent_next [8];
  logic [POS_W-1:0] name_pos, name_pos_next;
  logic [1:0]       name_prog, name_prog_next;
  logic [POS_W-1:0] name_end, name_end_next;
  logic [POS_W-1:0] fn_pos, fn_pos_next;
  logic [1:0]       fn_prog, fn_prog_next;
  logic [POS_W-1:0] fn_end, fn_end_next;
  logic             quote, quote_next;
  logic             too_long, too_long_next;

  logic [3:0]  hdr_idx;
  logic [39:0] name_win;
  logic [71:0] fn_win;
  logic        name_close_ok, fn_close_ok;

  assign hdr_idx  = 4'(pos - POS_W'(HDR_FIRST));
  assign name_win = {recent[4], recent[5], recent[6], recent[7], byte_value};
  assign fn_win   = {recent[0], recent[1], recent[2], recent[3], recent[4], recent[5],
                     recent[6], recent[7], byte_value};
  assign name_close_ok = {1'b0, pos} >= ({1'b0, name_pos} + PW1'(NAME_OFS));
  assign fn_close_ok   = {1'b0, pos} >= ({1'b0, fn_pos} + PW1'(FILENAME_OFS));

  always_comb begin
    pos_next       = pos;
    line_idx_next  = line_idx;
    l1_end_next    = l1_end;
    l2_end_next    = l2_end;
    l3_end_next    = l3_end;
    l3_seen_next   = l3_seen;
    hdr_bad_next   = hdr_bad;
    recent_next    = recent;
    name_pos_next  = name_pos;
    name_prog_next = name_prog;
    name_end_next  = name_end;
    fn_pos_next    = fn_pos;
    fn_prog_next   = fn_prog;
    fn_end_next    = fn_end;
    quote_next     = quote;
    too_long_next  = too_long;
    if (step) begin
      if (pos == POS_W'(MAX_BLOB_BYTES)) begin
        too_long_next = 1'b1;
      end else begin
        for (int i = 0; i < 7; i++) begin
          recent_next[i] = recent[i + 1];
        end
        recent_next[7] = byte_value;
        pos_next = pos + POS_W'(1);
        unique case (line_idx)
          LINE_ONE: begin
            if (byte_value == LF) begin
              l1_end_next   = pos;
              line_idx_next = LINE_TWO;
              if (pos < POS_W'(LINE1_MIN)) hdr_bad_next = 1'b1;
            end else begin
              if (pos >= POS_W'(HDR_FIRST) && pos <= POS_W'(HDR_LAST) &&
                  byte_value != FORM_WORD[hdr_idx]) begin
                hdr_bad_next = 1'b1;
              end
              if (byte_value == SQUOTE && (name_prog != PROG_NONE || fn_prog != PROG_NONE)) begin
                quote_next = 1'b1;
              end
              if (name_prog == PROG_OPEN && byte_value == DQUOTE && name_close_ok) begin
                name_end_next  = pos;
                name_prog_next = PROG_CLOSED;
              end
              if (fn_prog == PROG_OPEN && byte_value == DQUOTE && fn_close_ok) begin
                fn_end_next  = pos;
                fn_prog_next = PROG_CLOSED;
              end
              if (name_prog == PROG_NONE && name_win == NAME_WORD) begin
                name_pos_next  = pos - POS_W'(NAME_BACK);
                name_prog_next = PROG_OPEN;
              end
              if (fn_prog == PROG_NONE && fn_win == FILENAME_WORD) begin
                fn_pos_next  = pos - POS_W'(FILENAME_BACK);
                fn_prog_next = PROG_OPEN;
              end
            end
          end
          LINE_TWO: begin
            if (byte_value == LF) begin
              l2_end_next   = pos;
              line_idx_next = LINE_THREE;
            end
          end
          LINE_THREE: begin
            if (byte_value == LF) begin
              l3_end_next   = pos;
              l3_seen_next  = 1'b1;
              line_idx_next = LINE_REST;
            end
          end
          LINE_REST: begin
          end
        endcase
      end
    end
  end

  logic [EW-1:0] diff, type_len, content, blob_len;
  logic [EW-1:0] name_start_e, name_len_e, fn_start_e, fn_len_e, type_start_e;
  logic          ok_base, ok_all;

  always_comb begin
    diff     = EW'(l2_end_next) - EW'(l1_end_next);
    type_len = (diff > EW'(TYPE_SKIP + 1)) ? diff - EW'(TYPE_SKIP + 1) : '0;
    content  = (type_len != '0) ? EW'(l3_end_next) + EW'(1) : EW'(l2_end_next) + EW'(1);
    blob_len = too_long_next ? BLOB_OVER : EW'(pos_next);
    ok_base  = !too_long_next && line_idx_next >= LINE_THREE && !hdr_bad_next;
    ok_all   = ok_base && (type_len == '0 || l3_seen_next);
    name_start_e = EW'(name_pos_next) + EW'(NAME_OFS);
    name_len_e   = EW'(name_end_next) - name_start_e;
    fn_start_e   = EW'(fn_pos_next) + EW'(FILENAME_OFS);
    fn_len_e     = EW'(fn_end_next) - fn_start_e;
    type_start_e = EW'(l1_end_next) + EW'(TYPE_SKIP + 1);

    res = '0;
    res.blob_length = blob_len[16:0];
    if (ok_all) begin
      res.ok            = 1'b1;
      res.invalid_quote = quote_next;
      if (name_prog_next == PROG_CLOSED) begin
        res.name_found  = 1'b1;
        res.name_start  = name_start_e[15:0];
        res.name_length = name_len_e[16:0];
      end
      if (fn_prog_next == PROG_CLOSED) begin
        res.filename_found  = 1'b1;
        res.filename_start  = fn_start_e[15:0];
        res.filename_length = fn_len_e[16:0];
      end
      res.type_start    = type_start_e[15:0];
      res.type_length   = type_len[16:0];
      res.content_start = content[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && is_last)) begin
      pos       <= '0;
      line_idx  <= LINE_ONE;
      l1_end    <= '0;
      l2_end    <= '0;
      l3_end    <= '0;
      l3_seen   <= 1'b0;
      hdr_bad   <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        recent[i] <= '0;
      end
      name_pos  <= '0;
      name_prog <= PROG_NONE;
      name_end  <= '0;
      fn_pos    <= '0;
      fn_prog   <= PROG_NONE;
      fn_end    <= '0;
      quote     <= 1'b0;
      too_long  <= 1'b0;
    end else begin
      pos       <= pos_next;
      line_idx  <= line_idx_next;
      l1_end    <= l1_end_next;
      l2_end    <= l2_end_next;
      l3_end    <= l3_end_next;
      l3_seen   <= l3_seen_next;
      hdr_bad   <= hdr_bad_next;
      recent    <= recent_next;
      name_pos  <= name_pos_next;
      name_prog <= name_prog_next;
      name_end  <= name_end_next;
      fn_pos    <= fn_pos_next;
      fn_prog   <= fn_prog_next;
      fn_end    <= fn_end_next;
      quote     <= quote_next;
      too_long  <= too_long_next;
    end
  end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multipart part header parser.
//
// A directed table of parts comes first. It covers line one too short, a wrong
// form word, missing newlines, a content type with no third line, unclosed and
// empty values, single quotes and a part past the size limit. A part of exactly
// the size limit whose offsets wrap is in the table too. Random parts follow:
// mostly well-formed with random values, plus truncated, corrupted and noise
// parts. Every result is checked field by field against an in-bench parser
// model. Some table rows also carry pinned ok and blob length values. Both
// channels stall at random, with one stretch of parts at full rate.
// ----------------------------------------------------------------------------
module tb;
  import mpph_pkg::*;

  localparam int unsigned MAX_BYTES    = DEF_MAX_BLOB_BYTES;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned RANDOM_BYTES = 1800;
  localparam int unsigned RANDOM_PARTS = 36;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam logic [7:0]  FILL_BYTE    = 8'h78;

  typedef enum int {VAL_NONE, VAL_OPEN, VAL_CLOSED} value_state_e;
  typedef enum int {SEG_NAME, SEG_FILENAME, SEG_JUNK} segment_e;

  typedef struct {
    string       head;
    int unsigned fill;
    string       tail;
    bit          pinned;
    bit          pin_ok;
    int unsigned pin_blob;
  } part_row_t;

  typedef struct packed {
    bit          on;
    bit          ok;
    logic [16:0] blob;
  } pin_t;

  logic clk;
  logic rst;

  mpph_byte_if   req_if ();
  mpph_result_if rsp_if ();

  multipart_part_header_parser_unit u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // parser model state
  int unsigned  pos;
  int unsigned  l1_end;
  int unsigned  l2_end;
  int unsigned  l3_end;
  int unsigned  line_no;
  bit           l3_seen;
  bit           hdr_bad;
  bit           sq_seen;
  bit           overflow;
  logic [7:0]   window [9];
  int unsigned  nm_at;
  int unsigned  nm_close;
  value_state_e nm_st;
  int unsigned  fn_at;
  int unsigned  fn_close;
  value_state_e fn_st;

  result_t     located_q [$];
  pin_t        pin_q [$];
  pin_t        cur_pin;
  logic [7:0]  part_bytes [$];
  int unsigned errors;
  int unsigned quiet_cycles;
  bit          steady;

  part_row_t script [20] = '{
    '{"Content-Disposition: form-data; name=\"field\"; filename=\"a.txt\"\nContent-Type: text/plain\n\nhello",
      0, "", 1'b0, 1'b0, 0},
    '{"Content-Disposition: form-data\n\n", 0, "", 1'b0, 1'b0, 0},
    '{"Content-Disposition: form-dat\n\n", 0, "", 1'b1, 1'b0, 31},
    '{"Content-Disposition: form-date; name=\"x\"\n\nz", 0, "", 1'b1, 1'b0, 43},
    '{"Content-Disposition: form-data; name=\"x\"", 0, "", 1'b1, 1'b0, 40},
    '{"Content-Disposition: form-data; name=\"x\"\nContent-Type: x", 0, "", 1'b1, 1'b0, 56},
    '{"Content-Disposition: form-data; name=\"x\"\nContent-Type: text/plain\nbody",
      0, "", 1'b1, 1'b0, 70},
    '{"Content-Disposition: form-data; name=\"x\"\nContent-Type: \nbody", 0, "", 1'b0, 1'b0, 0},
    '{"Content-Disposition: form-data; name=\"x\"\nContent-Type: a\n\nbody", 0, "", 1'b0, 1'b0, 0},
    '{"Content-Disposition: form-data; name=\"it's\"\n\n", 0, "", 1'b0, 1'b0, 0},
    '{"Content-Disposition' form-data; name=\"x\"\n\n", 0, "", 1'b0, 1'b0, 0},
    '{"Content-Disposition: form-data; name=\"open\n\n", 0, "", 1'b0, 1'b0, 0},
    '{"Content-Disposition: form-data; name=\"\"\n\n", 0, "", 1'b0, 1'b0, 0},
    '{"Content-Disposition: form-data; filename=\"f\"\n\n", 0, "", 1'b0, 1'b0, 0},
    '{"Content-Disposition: form-data; name=x\"\n\n", 0, "", 1'b0, 1'b0, 0},
    '{"\n", 0, "", 1'b1, 1'b0, 1},
    '{"Content-Disposition: form-data; name=\"a\"\n\nname=\"b\"\n", 0, "", 1'b0, 1'b0, 0},
    '{"Content-Disposition: form-data; name=\"a\"; name=\"b\"\n\n", 0, "", 1'b0, 1'b0, 0},
    '{"Content-Disposition: form-data; name=\"big\"\nContent-Type: \n", 65500, "",
      1'b1, 1'b0, MAX_BYTES + 1},
    '{"Content-Disposition: form-data; ", 65468, "name=\"ab\"; filename=\"c'd\"\nshort\nbody",
      1'b1, 1'b1, MAX_BYTES}
  };

  function automatic void clear_parse_state();
    pos = 0; line_no = 0;
    l1_end = 0; l2_end = 0; l3_end = 0;
    l3_seen = 1'b0; hdr_bad = 1'b0; sq_seen = 1'b0; overflow = 1'b0;
    foreach (window[i]) window[i] = 8'h00;
    nm_at = 0; nm_close = 0; nm_st = VAL_NONE;
    fn_at = 0; fn_close = 0; fn_st = VAL_NONE;
  endfunction

  function automatic void scan_byte(logic [7:0] b, int unsigned p);
    for (int i = 0; i < 8; i++) window[i] = window[i + 1];
    window[8] = b;
    if (line_no == 0) begin
      if (b == LF) begin
        l1_end  = p;
        line_no = 1;
        if (p < LINE1_MIN) hdr_bad = 1'b1;
        return;
      end
      if (p >= HDR_FIRST && p <= HDR_LAST && b != FORM_WORD[p - HDR_FIRST]) hdr_bad = 1'b1;
      if (b == SQUOTE && (nm_st != VAL_NONE || fn_st != VAL_NONE)) sq_seen = 1'b1;
      if (nm_st == VAL_OPEN && b == DQUOTE && p >= nm_at + NAME_OFS) begin
        nm_close = p;
        nm_st    = VAL_CLOSED;
      end
      if (fn_st == VAL_OPEN && b == DQUOTE && p >= fn_at + FILENAME_OFS) begin
        fn_close = p;
        fn_st    = VAL_CLOSED;
      end
      if (nm_st == VAL_NONE &&
          {window[4], window[5], window[6], window[7], window[8]} == NAME_WORD) begin
        nm_at = p - NAME_BACK;
        nm_st = VAL_OPEN;
      end
      if (fn_st == VAL_NONE &&
          {window[0], window[1], window[2], window[3], window[4],
           window[5], window[6], window[7], window[8]} == FILENAME_WORD) begin
        fn_at = p - FILENAME_BACK;
        fn_st = VAL_OPEN;
      end
    end else if (line_no == 1) begin
      if (b == LF) begin
        l2_end  = p;
        line_no = 2;
      end
    end else if (line_no == 2) begin
      if (b == LF) begin
        l3_end  = p;
        l3_seen = 1'b1;
        line_no = 3;
      end
    end
  endfunction

  function automatic void locate_byte(logic [7:0] b, bit last);
    result_t     r;
    int unsigned blob;
    int unsigned len2;
    int unsigned tlen;
    int unsigned content;
    bit          good;
    r = '0;
    tlen = 0;
    content = 0;
    if (pos >= MAX_BYTES) begin
      overflow = 1'b1;
    end else begin
      scan_byte(b, pos);
      pos = pos + 1;
    end
    if (!last) return;
    blob = overflow ? MAX_BYTES + 1 : pos;
    good = !overflow && line_no >= 2 && !hdr_bad;
    if (good) begin
      len2 = l2_end - l1_end - 1;
      tlen = (len2 > TYPE_SKIP) ? len2 - TYPE_SKIP : 0;
      if (tlen > 0) begin
        if (l3_seen) content = l3_end + 1;
        else good = 1'b0;
      end else begin
        content = l2_end + 1;
      end
    end
    r.blob_length = 17'(blob);
    if (good) begin
      r.ok            = 1'b1;
      r.invalid_quote = sq_seen;
      if (nm_st == VAL_CLOSED) begin
        r.name_found  = 1'b1;
        r.name_start  = 16'(nm_at + NAME_OFS);
        r.name_length = 17'(nm_close - (nm_at + NAME_OFS));
      end
      if (fn_st == VAL_CLOSED) begin
        r.filename_found  = 1'b1;
        r.filename_start  = 16'(fn_at + FILENAME_OFS);
        r.filename_length = 17'(fn_close - (fn_at + FILENAME_OFS));
      end
      r.type_start    = 16'(l1_end + TYPE_SKIP + 1);
      r.type_length   = 17'(tlen);
      r.content_start = 17'(content);
    end
    located_q.push_back(r);
    clear_parse_state();
  endfunction

  function automatic void compare_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      errors++;
    end
  endfunction

  function automatic void check_result(result_t want, result_t got, pin_t pin);
    compare_field("ok", want.ok, got.ok);
    compare_field("invalid_quote", want.invalid_quote, got.invalid_quote);
    compare_field("name_found", want.name_found, got.name_found);
    compare_field("name_start", want.name_start, got.name_start);
    compare_field("name_length", want.name_length, got.name_length);
    compare_field("filename_found", want.filename_found, got.filename_found);
    compare_field("filename_start", want.filename_start, got.filename_start);
    compare_field("filename_length", want.filename_length, got.filename_length);
    compare_field("type_start", want.type_start, got.type_start);
    compare_field("type_length", want.type_length, got.type_length);
    compare_field("content_start", want.content_start, got.content_start);
    compare_field("blob_length", want.blob_length, got.blob_length);
    if (pin.on) begin
      compare_field("ok (table)", pin.ok, got.ok);
      compare_field("blob_length (table)", pin.blob, got.blob_length);
    end
  endfunction

  always @(posedge clk) begin
    result_t got;
    bit      moved;
    moved = 1'b0;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      moved = 1'b1;
      got = '{rsp_if.ok, rsp_if.invalid_quote,
              rsp_if.name_found, rsp_if.name_start, rsp_if.name_length,
              rsp_if.filename_found, rsp_if.filename_start, rsp_if.filename_length,
              rsp_if.type_start, rsp_if.type_length, rsp_if.content_start,
              rsp_if.blob_length};
      if (located_q.size() == 0) begin
        $error("result transaction with no expectation waiting");
        errors++;
      end else begin
        check_result(located_q.pop_front(), got, pin_q.pop_front());
      end
    end
    if (!rst && req_if.valid && req_if.ready) begin
      moved = 1'b1;
      locate_byte(req_if.byte_value, req_if.is_last);
      if (req_if.is_last) pin_q.push_back(cur_pin);
    end
    if (moved) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    rsp_if.ready <= steady || ($urandom_range(99) >= 34);
  end

  function automatic logic [7:0] any_byte();
    return ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(126, 32));
  endfunction

  function automatic logic [7:0] line_byte();
    logic [7:0] b;
    do b = any_byte(); while (b == LF);
    return b;
  endfunction

  function automatic void append_text(string s);
    for (int i = 0; i < s.len(); i++) part_bytes.push_back(s[i]);
  endfunction

  function automatic void build_row(part_row_t row);
    part_bytes.delete();
    append_text(row.head);
    repeat (row.fill) part_bytes.push_back(FILL_BYTE);
    append_text(row.tail);
  endfunction

  function automatic void build_random_part();
    segment_e    seg;
    int unsigned n;
    int unsigned line2_at;
    int unsigned roll;
    part_bytes.delete();
    append_text("Content-Disposition: form-data");
    repeat ($urandom_range(3)) begin
      seg = segment_e'($urandom_range(2));
      case (seg)
        SEG_NAME:     append_text("; name=\"");
        SEG_FILENAME: append_text("; filename=\"");
        default:      append_text("; ");
      endcase
      n = $urandom_range(6);
      repeat (n) part_bytes.push_back(line_byte());
      if (seg != SEG_JUNK && $urandom_range(7) != 0) part_bytes.push_back(DQUOTE);
    end
    part_bytes.push_back(LF);
    line2_at = part_bytes.size();
    if ($urandom_range(1) == 1) begin
      append_text("Content-Type: ");
      n = $urandom_range(10);
    end else begin
      n = $urandom_range(16);
    end
    repeat (n) part_bytes.push_back(line_byte());
    if (part_bytes.size() - line2_at > TYPE_SKIP) begin
      part_bytes.push_back(LF);
      repeat ($urandom_range(4)) part_bytes.push_back(line_byte());
    end
    part_bytes.push_back(LF);
    repeat ($urandom_range(24)) part_bytes.push_back(8'($urandom_range(255)));
    roll = $urandom_range(99);
    if (roll < 8) begin
      n = $urandom_range(part_bytes.size(), 1);
      while (part_bytes.size() > n) void'(part_bytes.pop_back());
    end else if (roll < 16) begin
      part_bytes[$urandom_range(part_bytes.size() - 1)] = 8'($urandom_range(255));
    end else if (roll < 22) begin
      part_bytes.delete();
      repeat ($urandom_range(40, 1)) part_bytes.push_back(8'($urandom_range(255)));
    end
  endfunction

  task automatic push_byte(logic [7:0] b, bit last);
    while (!steady && $urandom_range(99) < 34) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.byte_value <= b;
    req_if.is_last    <= last;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_part();
    for (int i = 0; i < part_bytes.size(); i++) push_byte(part_bytes[i], i == part_bytes.size() - 1);
  endtask

  initial begin
    int unsigned sent;
    int unsigned parts;
    rst               = 1'b1;
    req_if.valid      = 1'b0;
    req_if.byte_value = 8'h00;
    req_if.is_last    = 1'b0;
    rsp_if.ready      = 1'b0;
    steady            = 1'b0;
    cur_pin           = '0;
    errors            = 0;
    quiet_cycles      = 0;
    clear_parse_state();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      cur_pin = '{script[i].pinned, script[i].pin_ok, 17'(script[i].pin_blob)};
      build_row(script[i]);
      send_part();
    end

    cur_pin = '0;
    sent    = 0;
    parts   = 0;
    while (sent < RANDOM_BYTES || parts < RANDOM_PARTS) begin
      // hold both sides at full rate for a stretch of parts
      steady <= (parts >= 12 && parts < 20);
      build_random_part();
      send_part();
      sent += part_bytes.size();
      parts++;
    end
    steady       <= 1'b0;
    req_if.valid <= 1'b0;

    while (located_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/mpph_pkg.sv
hw/rtl/mpph_byte_if.sv
hw/rtl/mpph_result_if.sv
hw/rtl/mpph_scan.sv
hw/rtl/multipart_part_header_parser_unit.sv
dv/tb.sv
